// ===== rtl/fhss_pkg.sv =====
// ============================================================================
// fhss_pkg: shared types and constants of the floppy head seek sequencer
// Item and result layouts, configuration set, command and status codes.
// ============================================================================
`default_nettype none

package fhss_pkg;

	// Largest cylinder count the nudge bound is limited to.
	localparam int unsigned MaxCylinders = 128;

	// Command codes of the cmd field.
	localparam logic [1:0] CMD_SEEK  = 2'd0;
	localparam logic [1:0] CMD_RECAL = 2'd1;
	localparam logic [1:0] CMD_TICK  = 2'd2;
	localparam logic [1:0] CMD_NUDGE = 2'd3;

	// Status codes of a result.
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_TIMEOUT = 2'd1;
	localparam logic [1:0] ST_REJECT  = 2'd2;

	// Head position code for a head that has never been selected.
	localparam logic [1:0] HEAD_UNKNOWN = 2'd3;

	// Configuration register indexes.
	localparam logic [2:0] REG_CYL_COUNT   = 3'd0;
	localparam logic [2:0] REG_REV_WAIT    = 3'd1;
	localparam logic [2:0] REG_PRE_WAIT    = 3'd2;
	localparam logic [2:0] REG_STEP_WAIT   = 3'd3;
	localparam logic [2:0] REG_SEEK_SETTLE = 3'd4;
	localparam logic [2:0] REG_HEAD_SETTLE = 3'd5;
	localparam logic [2:0] REG_MAX_RECAL   = 3'd6;

	// Configuration reset values.
	localparam logic [7:0]  RST_CYL_COUNT   = 8'd80;
	localparam logic [15:0] RST_REV_WAIT    = 16'd180;
	localparam logic [15:0] RST_PRE_WAIT    = 16'd20;
	localparam logic [15:0] RST_STEP_WAIT   = 16'd30;
	localparam logic [15:0] RST_SEEK_SETTLE = 16'd150;
	localparam logic [15:0] RST_HEAD_SETTLE = 16'd1;
	localparam logic [7:0]  RST_MAX_RECAL   = 8'd80;

	// Sequencer phases.
	typedef enum logic [2:0] {
		PH_IDLE         = 3'd0,
		PH_SEEK_PRE     = 3'd1,
		PH_SEEK_STEP    = 3'd2,
		PH_SETTLE       = 3'd3,
		PH_RECAL_PRE    = 3'd4,
		PH_RECAL_STEP   = 3'd5,
		PH_RECAL_SETTLE = 3'd6
	} phase_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic [6:0] target_cylinder;
		logic       target_head;
		logic       at_track0;
	} item_t;

	typedef struct packed {
		logic              step_pulse;
		logic              step_inward;
		logic              head_strobe;
		logic              head_value;
		logic              busy_res;
		logic              done_res;
		logic [1:0]        status;
		logic              did_step;
		logic signed [7:0] current_cylinder;
	} result_t;

	typedef struct packed {
		logic [7:0]  cylinder_count;
		logic [15:0] reverse_wait;
		logic [15:0] head_pre_wait;
		logic [15:0] step_wait;
		logic [15:0] seek_settle;
		logic [15:0] head_settle;
		logic [7:0]  max_recal_steps;
	} cfg_t;

endpackage

`default_nettype wire

// ===== rtl/floppy_head_seek_sequencer_core.sv =====
// ============================================================================
// floppy_head_seek_sequencer_core: floppy head positioning sequencer
// Runs seek, recalibrate and nudge commands paced by tick items and issues
// step pulses and head-select strobes, one result item per input item.
// ============================================================================
//
//   channel  | signals                         | moves
//   ---------+---------------------------------+----------------------------
//   cmd      | cmd_valid, cmd_stall, cmd_item  | command or tick item in
//   res      | res_valid, res_stall, res_item  | one result item per input item
//   cfg      | cfg_we, cfg_index, cfg_data     | register write, no read-back
//
// One item per clock cycle unless res_stall holds the result register; a taken item
// waits in the input register and its result is offered from the result register.
// The whole state update for an item is combinational between the two registers.
// Reset clears the sequencer state and loads the register defaults.
// A stalled result holds the result register; the input register then fills
// and cmd_stall rises until the result is taken.
`default_nettype none

module floppy_head_seek_sequencer_core import fhss_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cmd_valid,
	output logic             cmd_stall,
	input  wire item_t       cmd_item,
	output logic             res_valid,
	input  wire logic        res_stall,
	output result_t          res_item,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	cfg_t    cfg_q;
	item_t   item_s1;
	logic    valid_s1;
	result_t res_q;
	result_t res_comb;
	logic    res_valid_q;
	logic    can_load;
	logic    advance;
	logic    take_in;

	// Handshake: the input register moves on whenever the result register is free.
	assign can_load  = !res_valid_q || !res_stall;
	assign advance   = valid_s1 && can_load;
	assign cmd_stall = valid_s1 && !can_load;
	assign take_in   = cmd_valid && !cmd_stall;
	assign res_valid = res_valid_q;
	assign res_item  = res_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cylinder_count  <= RST_CYL_COUNT;
			cfg_q.reverse_wait    <= RST_REV_WAIT;
			cfg_q.head_pre_wait   <= RST_PRE_WAIT;
			cfg_q.step_wait       <= RST_STEP_WAIT;
			cfg_q.seek_settle     <= RST_SEEK_SETTLE;
			cfg_q.head_settle     <= RST_HEAD_SETTLE;
			cfg_q.max_recal_steps <= RST_MAX_RECAL;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CYL_COUNT:   cfg_q.cylinder_count  <= cfg_data[7:0];
				REG_REV_WAIT:    cfg_q.reverse_wait    <= cfg_data;
				REG_PRE_WAIT:    cfg_q.head_pre_wait   <= cfg_data;
				REG_STEP_WAIT:   cfg_q.step_wait       <= cfg_data;
				REG_SEEK_SETTLE: cfg_q.seek_settle     <= cfg_data;
				REG_HEAD_SETTLE: cfg_q.head_settle     <= cfg_data;
				REG_MAX_RECAL:   cfg_q.max_recal_steps <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	// Input register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (take_in) begin
			item_s1 <= cmd_item;
		end
	end

	fhss_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.cfg     (cfg_q),
		.res     (res_comb)
	);

	// Result register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (can_load) begin
			res_valid_q <= valid_s1;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_comb;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/fhss_seq.sv =====
// ============================================================================
// fhss_seq: head positioning state and its per-item update
// Holds the sequencer state and computes the result of one item combinationally.
// ============================================================================
`default_nettype none

module fhss_seq import fhss_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    advance,
	input  wire item_t   item,
	input  wire cfg_t    cfg,
	output result_t      res
);

	logic signed [7:0] cyl_q, cyl_n;
	logic [1:0]        head_q, head_n;
	logic              last_in_q, last_in_n;
	logic              nudge_in_q, nudge_in_n;
	phase_t            phase_q, phase_n, ph_cur;
	logic [15:0]       wait_q, wait_n;
	logic [7:0]        steps_q, steps_n;
	logic [7:0]        recal_q, recal_n;
	logic [1:0]        pend_q, pend_n;

	// Seek start terms, shared by seek and nudge.
	logic [7:0]        lim;
	logic signed [8:0] nudge_raw;
	logic [6:0]        nudge_cyl;
	logic              nudge_flag;
	logic [6:0]        tgt_cyl;
	logic [1:0]        tgt_head;
	logic signed [8:0] diff;
	logic              seek_in;
	logic [7:0]        seek_n;
	logic              seek_moves;
	logic [15:0]       pre_wait;
	logic [15:0]       settle;

	// Nudge bound: cylinder count held inside two and the cylinder limit.
	always_comb begin
		if (cfg.cylinder_count > 8'(MaxCylinders - 1)) begin
			lim = 8'(MaxCylinders - 1) + 8'd1;
		end else if (cfg.cylinder_count < 8'd2) begin
			lim = 8'd2;
		end else begin
			lim = cfg.cylinder_count;
		end
	end

	// Nudge target: one cylinder in the nudge direction, folded back at the ends.
	always_comb begin
		nudge_raw  = nudge_in_q ? (9'(cyl_q) + 9'sd1) : (9'(cyl_q) - 9'sd1);
		nudge_flag = nudge_in_q;
		nudge_cyl  = nudge_raw[6:0];
		if (nudge_raw > ($signed({1'b0, lim}) - 9'sd1)) begin
			nudge_cyl  = 7'(cyl_q - 8'sd1);
			nudge_flag = 1'b0;
		end else if (nudge_raw < 9'sd0) begin
			nudge_cyl  = 7'd1;
			nudge_flag = 1'b1;
		end
	end

	// Distance, direction and pre-wait of a seek about to start.
	always_comb begin
		tgt_cyl    = (item.cmd == CMD_NUDGE) ? nudge_cyl : item.target_cylinder;
		tgt_head   = (item.cmd == CMD_NUDGE) ? head_q : {1'b0, item.target_head};
		diff       = $signed({2'b00, tgt_cyl}) - 9'(cyl_q);
		seek_in    = ~diff[8];
		seek_n     = diff[8] ? 8'(-diff) : 8'(diff);
		seek_moves = (diff != 9'sd0);
		pre_wait   = cfg.head_pre_wait;
		if (seek_moves && (seek_in != last_in_q)) begin
			pre_wait = (cfg.reverse_wait > cfg.head_pre_wait) ?
				cfg.reverse_wait : cfg.head_pre_wait;
		end
	end

	// Settle time after the seek steps are done.
	always_comb begin
		settle = 16'd0;
		if (head_q != pend_q) begin
			settle = cfg.head_settle;
		end
		if ((phase_q == PH_SEEK_STEP) && (cfg.seek_settle > settle)) begin
			settle = cfg.seek_settle;
		end
	end

	// Next state and result of the item in the input register.
	always_comb begin
		unique case (phase_q)
			PH_IDLE, PH_SEEK_PRE, PH_SEEK_STEP, PH_SETTLE,
			PH_RECAL_PRE, PH_RECAL_STEP, PH_RECAL_SETTLE: ph_cur = phase_q;
			default: ph_cur = PH_IDLE;
		endcase

		cyl_n      = cyl_q;
		head_n     = head_q;
		last_in_n  = last_in_q;
		nudge_in_n = nudge_in_q;
		phase_n    = ph_cur;
		wait_n     = wait_q;
		steps_n    = steps_q;
		recal_n    = recal_q;
		pend_n     = pend_q;
		res        = '0;

		if (item.cmd != CMD_TICK) begin
			if (ph_cur != PH_IDLE) begin
				res.status = ST_REJECT;
			end else if (item.cmd == CMD_RECAL) begin
				recal_n = 8'd0;
				wait_n  = cfg.reverse_wait;
				phase_n = PH_RECAL_PRE;
			end else begin
				if (seek_moves) begin
					last_in_n = seek_in;
				end
				steps_n = seek_n;
				pend_n  = tgt_head;
				wait_n  = pre_wait;
				phase_n = PH_SEEK_PRE;
				if (item.cmd == CMD_NUDGE) begin
					nudge_in_n = ~nudge_flag;
				end
			end
		end else if (ph_cur != PH_IDLE) begin
			if (wait_q != 16'd0) begin
				wait_n = wait_q - 16'd1;
			end else begin
				unique case (ph_cur)
					PH_SEEK_PRE, PH_SEEK_STEP: begin
						if (steps_q != 8'd0) begin
							res.step_pulse  = 1'b1;
							res.step_inward = last_in_q;
							cyl_n   = last_in_q ? (cyl_q + 8'sd1) : (cyl_q - 8'sd1);
							steps_n = steps_q - 8'd1;
							wait_n  = cfg.step_wait;
							phase_n = PH_SEEK_STEP;
						end else begin
							if (head_q != pend_q) begin
								res.head_strobe = 1'b1;
								res.head_value  = pend_q[0];
								head_n          = pend_q;
							end
							if (settle == 16'd0) begin
								res.done_res = 1'b1;
								phase_n      = PH_IDLE;
							end else begin
								wait_n  = settle;
								phase_n = PH_SETTLE;
							end
						end
					end
					PH_SETTLE: begin
						res.done_res = 1'b1;
						phase_n      = PH_IDLE;
					end
					PH_RECAL_PRE, PH_RECAL_STEP: begin
						if (item.at_track0) begin
							res.head_strobe = 1'b1;
							wait_n          = cfg.seek_settle;
							phase_n         = PH_RECAL_SETTLE;
						end else begin
							res.step_pulse = 1'b1;
							if (recal_q >= cfg.max_recal_steps) begin
								res.done_res = 1'b1;
								res.status   = ST_TIMEOUT;
								phase_n      = PH_IDLE;
							end else begin
								recal_n = recal_q + 8'd1;
								wait_n  = cfg.step_wait;
								phase_n = PH_RECAL_STEP;
							end
						end
					end
					default: begin
						phase_n = ph_cur;
					end
				endcase
			end
			// Recalibrate completes once its settle wait has run out.
			if ((phase_n == PH_RECAL_SETTLE) && (wait_n == 16'd0)) begin
				head_n       = 2'd0;
				cyl_n        = 8'sd0;
				last_in_n    = 1'b0;
				res.done_res = 1'b1;
				res.did_step = (recal_q != 8'd0);
				phase_n      = PH_IDLE;
			end
		end

		res.busy_res         = (phase_n != PH_IDLE);
		res.current_cylinder = cyl_n;
	end

	// State registers, updated once per processed item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cyl_q      <= -8'sd1;
			head_q     <= HEAD_UNKNOWN;
			last_in_q  <= 1'b0;
			nudge_in_q <= 1'b0;
			phase_q    <= PH_IDLE;
			wait_q     <= 16'd0;
			steps_q    <= 8'd0;
			recal_q    <= 8'd0;
			pend_q     <= 2'd0;
		end else if (advance) begin
			cyl_q      <= cyl_n;
			head_q     <= head_n;
			last_in_q  <= last_in_n;
			nudge_in_q <= nudge_in_n;
			phase_q    <= phase_n;
			wait_q     <= wait_n;
			steps_q    <= steps_n;
			recal_q    <= recal_n;
			pend_q     <= pend_n;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/fhss_checker.sv =====
// ============================================================================
// fhss_checker: port-level checks of the head seek sequencer
// Watches the result channel and relates each result to the previous one.
// ============================================================================
`default_nettype none

module fhss_checker import fhss_pkg::*; (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        res_valid,
	input wire logic        res_stall,
	input wire result_t     res_item
);

	logic last_busy_q;
	logic res_take;

	assign res_take = res_valid && !res_stall;

	// Busy flag of the most recently delivered result item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_busy_q <= 1'b0;
		end else if (res_take) begin
			last_busy_q <= res_item.busy_res;
		end
	end

	// A stalled result stays offered.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid)
		else $error("result valid dropped while stalled");

	// A stalled result keeps its payload.
	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> $stable(res_item))
		else $error("result payload changed while stalled");

	// A command is rejected only while an earlier one is still running.
	a_reject_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_take && (res_item.status == ST_REJECT) |-> last_busy_q)
		else $error("command rejected while sequencer was idle");

	// A completion follows a result that reported the sequencer busy.
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_take && res_item.done_res |-> last_busy_q)
		else $error("completion reported without a running command");

endmodule

bind floppy_head_seek_sequencer_core fhss_checker u_fhss_checker (.*);

`default_nettype wire

// ===== dv/tb_floppy_head_seek_sequencer_core.sv =====
// ============================================================================
// tb_floppy_head_seek_sequencer_core: self-checking bench of the head sequencer
// A tracker class mirrors the positioning state and predicts one result per
// accepted command or tick item. Directed commands at several register
// settings come first, then random command streams under varied idling
// and back-pressure, and a recalibrate at the largest step limit.
// ============================================================================
`default_nettype none

module tb_floppy_head_seek_sequencer_core;
	import fhss_pkg::*;

	localparam int RunLimit = 12 * 2_000_000;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

	// Tracks head position and sequencer phase, and holds predicted results.
	class head_tracker;
		cfg_t        regs;
		int          cyl_pos;
		logic [1:0]  head_pos;
		bit          last_inward;
		bit          nudge_inward;
		phase_t      phase;
		logic [15:0] wait_count;
		logic [7:0]  steps_left;
		logic [7:0]  recal_steps;
		logic [1:0]  pending_head;
		result_t     positioning_q[$];
		int          mismatches;
		int          n_seek, n_recal, n_nudge, n_tick;
		int          n_pulse, n_done, n_timeout, n_reject;

		function new();
			regs = '{RST_CYL_COUNT, RST_REV_WAIT, RST_PRE_WAIT, RST_STEP_WAIT,
				RST_SEEK_SETTLE, RST_HEAD_SETTLE, RST_MAX_RECAL};
			cyl_pos = -1;
			head_pos = HEAD_UNKNOWN;
			last_inward = 1'b0;
			nudge_inward = 1'b0;
			phase = PH_IDLE;
			wait_count = '0;
			steps_left = '0;
			recal_steps = '0;
			pending_head = '0;
		endfunction

		function void write_reg(logic [2:0] index, logic [15:0] data);
			case (index)
			REG_CYL_COUNT:   regs.cylinder_count = data[7:0];
			REG_REV_WAIT:    regs.reverse_wait = data;
			REG_PRE_WAIT:    regs.head_pre_wait = data;
			REG_STEP_WAIT:   regs.step_wait = data;
			REG_SEEK_SETTLE: regs.seek_settle = data;
			REG_HEAD_SETTLE: regs.head_settle = data;
			REG_MAX_RECAL:   regs.max_recal_steps = data[7:0];
			default: ;
			endcase
		endfunction

		function bit busy();
			return phase != PH_IDLE;
		endfunction

		function int pending();
			return positioning_q.size();
		endfunction

		// A reversal of direction waits the longer of the two pre-waits.
		function void start_seek(int target, logic [1:0] head);
			int diff;
			int n;
			bit inward;
			logic [15:0] pre;
			diff = target - cyl_pos;
			inward = diff >= 0;
			n = inward ? diff : -diff;
			pre = regs.head_pre_wait;
			if (n > 0 && inward != last_inward && regs.reverse_wait > pre)
				pre = regs.reverse_wait;
			if (n > 0)
				last_inward = inward;
			steps_left = n[7:0];
			pending_head = head;
			wait_count = pre;
			phase = PH_SEEK_PRE;
		endfunction

		function result_t predict(item_t it);
			result_t r;
			int lim;
			int c;
			logic [15:0] settle;
			bit any_step;
			r = '0;
			if (it.cmd != CMD_TICK) begin
				if (phase != PH_IDLE) begin
					r.status = ST_REJECT;
				end else if (it.cmd == CMD_SEEK) begin
					start_seek(int'(it.target_cylinder), {1'b0, it.target_head});
				end else if (it.cmd == CMD_RECAL) begin
					recal_steps = '0;
					wait_count = regs.reverse_wait;
					phase = PH_RECAL_PRE;
				end else begin
					// Nudge one cylinder, bouncing off both ends of the disk.
					lim = int'(regs.cylinder_count);
					if (lim > MaxCylinders)
						lim = MaxCylinders;
					if (lim < 2)
						lim = 2;
					c = nudge_inward ? cyl_pos + 1 : cyl_pos - 1;
					if (c > lim - 1) begin
						c = cyl_pos - 1;
						nudge_inward = 1'b0;
					end else if (c < 0) begin
						c = 1;
						nudge_inward = 1'b1;
					end
					start_seek(c, head_pos);
					nudge_inward = !nudge_inward;
				end
			end else if (phase != PH_IDLE) begin
				if (wait_count != 0) begin
					wait_count = wait_count - 16'd1;
				end else if (phase == PH_SEEK_PRE || phase == PH_SEEK_STEP) begin
					if (steps_left != 0) begin
						r.step_pulse = 1'b1;
						r.step_inward = last_inward;
						cyl_pos += last_inward ? 1 : -1;
						steps_left = steps_left - 8'd1;
						wait_count = regs.step_wait;
						phase = PH_SEEK_STEP;
					end else begin
						any_step = phase == PH_SEEK_STEP;
						settle = '0;
						if (head_pos != pending_head) begin
							r.head_strobe = 1'b1;
							r.head_value = pending_head[0];
							head_pos = pending_head;
							settle = regs.head_settle;
						end
						if (any_step && regs.seek_settle > settle)
							settle = regs.seek_settle;
						if (settle == 0) begin
							r.done_res = 1'b1;
							phase = PH_IDLE;
						end else begin
							wait_count = settle;
							phase = PH_SETTLE;
						end
					end
				end else if (phase == PH_SETTLE) begin
					r.done_res = 1'b1;
					phase = PH_IDLE;
				end else if (phase == PH_RECAL_PRE || phase == PH_RECAL_STEP) begin
					if (it.at_track0) begin
						r.head_strobe = 1'b1;
						wait_count = regs.seek_settle;
						phase = PH_RECAL_SETTLE;
					end else begin
						r.step_pulse = 1'b1;
						if (recal_steps >= regs.max_recal_steps) begin
							r.done_res = 1'b1;
							r.status = ST_TIMEOUT;
							phase = PH_IDLE;
						end else begin
							recal_steps = recal_steps + 8'd1;
							wait_count = regs.step_wait;
							phase = PH_RECAL_STEP;
						end
					end
				end
				// Recalibrate completes as soon as its settle count runs out.
				if (phase == PH_RECAL_SETTLE && wait_count == 0) begin
					head_pos = 2'd0;
					cyl_pos = 0;
					last_inward = 1'b0;
					r.done_res = 1'b1;
					r.did_step = recal_steps != 0;
					phase = PH_IDLE;
				end
			end
			r.busy_res = phase != PH_IDLE;
			r.current_cylinder = cyl_pos[7:0];
			return r;
		endfunction

		function void accept_item(item_t it);
			result_t r;
			r = predict(it);
			positioning_q.push_back(r);
			case (it.cmd)
			CMD_SEEK:  n_seek++;
			CMD_RECAL: n_recal++;
			CMD_NUDGE: n_nudge++;
			default:   n_tick++;
			endcase
			n_pulse += int'(r.step_pulse);
			n_done += int'(r.done_res);
			if (r.status == ST_TIMEOUT)
				n_timeout++;
			if (r.status == ST_REJECT)
				n_reject++;
		endfunction

		function void compare_field(string name, logic [7:0] want, logic [7:0] got,
				bit as_signed);
			if (got !== want) begin
				if (as_signed)
					$error("%s: expected %0d, actual %0d", name, $signed(want), $signed(got));
				else
					$error("%s: expected %0d, actual %0d", name, want, got);
				mismatches++;
			end
		endfunction

		function void compare_result(result_t got);
			result_t want;
			if (positioning_q.size() == 0) begin
				$error("result item arrived with no item outstanding");
				mismatches++;
				return;
			end
			want = positioning_q.pop_front();
			compare_field("step_pulse", 8'(want.step_pulse), 8'(got.step_pulse), 1'b0);
			compare_field("step_inward", 8'(want.step_inward), 8'(got.step_inward), 1'b0);
			compare_field("head_strobe", 8'(want.head_strobe), 8'(got.head_strobe), 1'b0);
			compare_field("head_value", 8'(want.head_value), 8'(got.head_value), 1'b0);
			compare_field("busy_res", 8'(want.busy_res), 8'(got.busy_res), 1'b0);
			compare_field("done_res", 8'(want.done_res), 8'(got.done_res), 1'b0);
			compare_field("status", 8'(want.status), 8'(got.status), 1'b0);
			compare_field("did_step", 8'(want.did_step), 8'(got.did_step), 1'b0);
			compare_field("current_cylinder", want.current_cylinder,
				got.current_cylinder, 1'b1);
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cmd_valid = 1'b0;
	logic        cmd_stall;
	item_t       cmd_item = '0;
	logic        res_valid;
	logic        res_stall = 1'b0;
	result_t     res_item;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = REG_CYL_COUNT;
	logic [15:0] cfg_data = '0;

	idle_mode_e  idle_mode = IDLE_NONE;
	int          hold_requests = 0;
	int          hold_served = 0;
	int          hold_left = 0;

	head_tracker sb = new();

	floppy_head_seek_sequencer_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd_item  (cmd_item),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_item  (res_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	function automatic bit sender_gap();
		case (idle_mode)
		IDLE_SENDER: return $urandom_range(0, 99) < 65;
		IDLE_BOTH:   return $urandom_range(0, 99) < 10;
		default:     return 1'b0;
		endcase
	endfunction

	function automatic bit receiver_stall();
		case (idle_mode)
		IDLE_RECEIVER: return $urandom_range(0, 99) < 65;
		IDLE_BOTH:     return $urandom_range(0, 99) < 10;
		default:       return 1'b0;
		endcase
	endfunction

	// Receiver: random stalls, or a long hold-off when one is requested.
	always @(negedge clk) begin
		if (hold_left == 0 && hold_served != hold_requests) begin
			hold_served <= hold_requests;
			hold_left <= 40;
			res_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			res_stall <= 1'b1;
		end else begin
			res_stall <= receiver_stall();
		end
	end

	// Every accepted result item is checked against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall)
			sb.compare_result(res_item);
	end

	function automatic item_t command(logic [1:0] code, int cyl, logic head);
		item_t it;
		it.cmd = code;
		it.target_cylinder = cyl[6:0];
		it.target_head = head;
		it.at_track0 = 1'($urandom_range(0, 1));
		return it;
	endfunction

	// A tick carries random unused fields; track zero shows with the given odds.
	function automatic item_t tick_item(int track0_pct);
		item_t it;
		it.cmd = CMD_TICK;
		it.target_cylinder = 7'($urandom_range(0, 127));
		it.target_head = 1'($urandom_range(0, 1));
		it.at_track0 = $urandom_range(0, 99) < track0_pct;
		return it;
	endfunction

	// Mostly ticks so that commands run to completion; targets lean toward
	// the low cylinders to keep seeks short.
	function automatic item_t random_item(int track0_pct);
		int cyl;
		if ($urandom_range(0, 99) < 70)
			return tick_item(track0_pct);
		cyl = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 127) : $urandom_range(0, 7);
		case ($urandom_range(0, 3))
		0, 1:    return command(CMD_SEEK, cyl, 1'($urandom_range(0, 1)));
		2:       return command(CMD_RECAL, cyl, 1'($urandom_range(0, 1)));
		default: return command(CMD_NUDGE, cyl, 1'($urandom_range(0, 1)));
		endcase
	endfunction

	function automatic cfg_t random_cfg();
		cfg_t c;
		c.cylinder_count = 8'($urandom_range(2, 128));
		c.reverse_wait = 16'($urandom_range(0, 3));
		c.head_pre_wait = 16'($urandom_range(0, 3));
		c.step_wait = 16'($urandom_range(0, 3));
		c.seek_settle = 16'($urandom_range(0, 3));
		c.head_settle = 16'($urandom_range(0, 3));
		c.max_recal_steps = 8'($urandom_range(1, 12));
		return c;
	endfunction

	// Offer one item, with random gaps before it, until it is taken.
	task automatic send_item(input item_t it);
		@(negedge clk);
		while (sender_gap()) begin
			cmd_valid <= 1'b0;
			@(negedge clk);
		end
		cmd_valid <= 1'b1;
		cmd_item <= it;
		do @(posedge clk); while (cmd_stall);
		sb.accept_item(it);
	endtask

	// Feed ticks until the current command has finished.
	task automatic run_to_idle(input int track0_pct);
		while (sb.busy())
			send_item(tick_item(track0_pct));
	endtask

	task automatic send_and_finish(input item_t it, input int track0_pct);
		send_item(it);
		run_to_idle(track0_pct);
	endtask

	// Stop offering items and wait for every outstanding result.
	task automatic drain_all();
		@(negedge clk);
		cmd_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] index, input logic [15:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		@(posedge clk);
		sb.write_reg(index, data);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Registers change only with the pipeline empty.
	task automatic begin_phase(input cfg_t c, input idle_mode_e mode);
		drain_all();
		write_reg(REG_CYL_COUNT, {8'd0, c.cylinder_count});
		write_reg(REG_REV_WAIT, c.reverse_wait);
		write_reg(REG_PRE_WAIT, c.head_pre_wait);
		write_reg(REG_STEP_WAIT, c.step_wait);
		write_reg(REG_SEEK_SETTLE, c.seek_settle);
		write_reg(REG_HEAD_SETTLE, c.head_settle);
		write_reg(REG_MAX_RECAL, {8'd0, c.max_recal_steps});
		@(posedge clk);
		idle_mode = mode;
	endtask

	initial begin : watchdog
		#(RunLimit);
		$display("tb_floppy_head_seek_sequencer_core NOT OK");
		$finish;
	end

	initial begin : stimulus
		cfg_t c;
		int track0_pct;
		int k;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Register defaults: seek from the unknown cylinder, then a head-only
		// change.
		send_and_finish(command(CMD_SEEK, 0, 1'b1), 0);
		send_and_finish(command(CMD_SEEK, 0, 1'b0), 0);

		// Short waits with zero settle times.
		c = '{8'd128, 16'd2, 16'd1, 16'd0, 16'd0, 16'd0, 8'd3};
		begin_phase(c, IDLE_NONE);
		send_item(tick_item(50));
		send_and_finish(command(CMD_SEEK, 127, 1'b0), 0);
		send_and_finish(command(CMD_NUDGE, 0, 1'b0), 0);
		send_and_finish(command(CMD_NUDGE, 0, 1'b0), 0);
		send_and_finish(command(CMD_NUDGE, 0, 1'b0), 0);
		send_and_finish(command(CMD_SEEK, 0, 1'b1), 0);
		send_and_finish(command(CMD_NUDGE, 0, 1'b0), 0);
		send_and_finish(command(CMD_SEEK, 0, 1'b1), 0);
		send_and_finish(command(CMD_SEEK, 0, 1'b1), 0);
		send_and_finish(command(CMD_SEEK, 0, 1'b0), 0);
		// Commands that arrive while a seek is running are rejected.
		send_item(command(CMD_SEEK, 5, 1'b0));
		send_item(command(CMD_RECAL, 0, 1'b0));
		send_item(command(CMD_NUDGE, 0, 1'b0));
		send_and_finish(command(CMD_SEEK, 9, 1'b1), 0);
		// Recalibrate already at track zero, timing out, and after two steps.
		send_and_finish(command(CMD_RECAL, 0, 1'b0), 100);
		send_and_finish(command(CMD_RECAL, 0, 1'b0), 0);
		send_item(command(CMD_RECAL, 0, 1'b0));
		repeat (4) send_item(tick_item(0));
		run_to_idle(100);

		// Two-cylinder disk: the nudge bounces between both ends.
		c = '{8'd2, 16'd0, 16'd0, 16'd1, 16'd1, 16'd3, 8'd1};
		begin_phase(c, IDLE_NONE);
		send_and_finish(command(CMD_SEEK, 1, 1'b1), 0);
		repeat (3) send_and_finish(command(CMD_NUDGE, 0, 1'b0), 0);
		send_and_finish(command(CMD_RECAL, 0, 1'b0), 0);
		send_and_finish(command(CMD_SEEK, 3, 1'b0), 0);

		// Random command streams under the idling patterns.
		for (int p = 0; p < 6; p++) begin
			c = random_cfg();
			if (p == 1) begin
				c.cylinder_count = 8'd2;
				c.max_recal_steps = 8'd1;
			end
			if (p == 2) begin
				c.cylinder_count = 8'd128;
				c.max_recal_steps = 8'd255;
			end
			track0_pct = $urandom_range(5, 30);
			begin_phase(c, idle_mode_e'(p % 4));
			// Hold the result side off while items keep coming.
			if (p == 4)
				hold_requests++;
			for (k = 0; k < 50; k++) begin
				send_item(random_item(track0_pct));
				if (p == 5 && k == 25)
					drain_all();
			end
			run_to_idle(track0_pct);
		end

		// Zero waits with the longest step limit, then a short random burst.
		c = '{8'd2, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 8'd255};
		begin_phase(c, IDLE_BOTH);
		send_and_finish(command(CMD_RECAL, 0, 1'b0), 0);
		for (k = 0; k < 30; k++)
			send_item(random_item(20));
		run_to_idle(20);

		drain_all();
		$display("Covered %0d seeks, %0d recalibrates, %0d nudges and %0d ticks.",
			sb.n_seek, sb.n_recal, sb.n_nudge, sb.n_tick);
		$display("Saw %0d step pulses, %0d completions, %0d timeouts, %0d rejects.",
			sb.n_pulse, sb.n_done, sb.n_timeout, sb.n_reject);
		if (sb.mismatches == 0) begin
			$display("tb_floppy_head_seek_sequencer_core OK");
		end else begin
			$display("tb_floppy_head_seek_sequencer_core NOT OK");
		end
		$finish;
	end

endmodule

`default_nettype wire
